// File: hw/rtl/dhlt_pkg.sv
// Shared constants for the DH link transform: pipeline depths and fixed-point values.
package dhlt_pkg;

  // Sine/cosine unit depth, and total depth of the top-level pipeline.
  localparam int unsigned SC_STAGES  = 9;
  localparam int unsigned TOP_STAGES = SC_STAGES + 2;

  localparam logic signed [35:0] HALF_PI      = 36'sd1686629713;
  localparam logic signed [35:0] HALF_PI_HALF = 36'sd843314856;
  localparam logic signed [35:0] FOUR_HALF_PI = 36'sd6746518852;
  localparam logic [30:0]        Q30_ONE      = 31'd1073741824;

  // Reciprocal multipliers for exact truncating division of values below 2^30:
  // m = ceil(2^s / d) with s = 30 + ceil(log2 d).
  localparam int unsigned SH_42 = 36;
  localparam int unsigned SH_20 = 35;
  localparam int unsigned SH_6  = 33;
  localparam int unsigned SH_56 = 36;
  localparam int unsigned SH_30 = 35;
  localparam int unsigned SH_12 = 34;
  localparam logic [30:0] MAG_42 = 31'(((64'd1 << 36) + 64'd41) / 64'd42);
  localparam logic [30:0] MAG_20 = 31'(((64'd1 << 35) + 64'd19) / 64'd20);
  localparam logic [30:0] MAG_6  = 31'(((64'd1 << 33) + 64'd5) / 64'd6);
  localparam logic [30:0] MAG_56 = 31'(((64'd1 << 36) + 64'd55) / 64'd56);
  localparam logic [30:0] MAG_30 = 31'(((64'd1 << 35) + 64'd29) / 64'd30);
  localparam logic [30:0] MAG_12 = 31'(((64'd1 << 34) + 64'd11) / 64'd12);

endpackage

// File: hw/rtl/dhlt_sincos.sv
// Pipelined Q30 sine/cosine of a Q3.13 angle: quadrant reduction and Horner polynomials.
module dhlt_sincos import dhlt_pkg::*; (
  input  logic                        clk_i,
  input  logic [SC_STAGES-1:0]        en_i,
  input  logic signed [15:0]          angle_i,
  output logic signed [31:0]          sin_o,
  output logic signed [31:0]          cos_o
);

  function automatic logic [29:0] div_by(input logic [29:0] x, input logic [30:0] m,
                                         input int unsigned sh);
    logic [60:0] pr;
    pr = 61'(x) * 61'(m);
    return 30'(pr >> sh);
  endfunction

  function automatic logic [29:0] mul_q30(input logic [29:0] x, input logic [30:0] t);
    logic [60:0] pr;
    pr = 61'(x) * 61'(t);
    return 30'(pr >> 30);
  endfunction

  // carried values
  logic [29:0] u_q    [0:6];
  logic [29:0] u2_q   [1:6];
  logic        sgn_q  [0:7];
  logic [1:0]  quad_q [0:7];

  logic [29:0] d3s_q, d3c_q, p4s_q, p4c_q, d5s_q, d5c_q;
  logic [29:0] p6s_q, p6c_q, d7s_q, d7c_q, s8_q, pc8_q;
  logic signed [31:0] sin_q, cos_q;

  // stage 1: range reduction by nearest multiple of pi/2
  logic signed [35:0] off_d, y_d;
  logic [2:0]         q_d;
  logic [35:0]        ymag_d;

  always_comb begin
    off_d = (36'(angle_i) <<< 17) + FOUR_HALF_PI;
    q_d   = '0;
    for (int k = 1; k < 8; k++) begin
      q_d = q_d + 3'(off_d + HALF_PI_HALF >= 36'(k) * HALF_PI);
    end
    y_d    = off_d - 36'($signed({1'b0, q_d})) * HALF_PI;
    ymag_d = y_d[35] ? 36'(-y_d) : 36'(y_d);
  end

  logic [59:0] sq_d;
  assign sq_d = 60'(u_q[0]) * 60'(u_q[0]);

  logic [30:0] t4s, t4c, t6s, t6c, t8s, t8c, c9;
  logic signed [31:0] sy9, cy9;
  assign t4s = Q30_ONE - 31'(d3s_q);
  assign t4c = Q30_ONE - 31'(d3c_q);
  assign t6s = Q30_ONE - 31'(d5s_q);
  assign t6c = Q30_ONE - 31'(d5c_q);
  assign t8s = Q30_ONE - 31'(d7s_q);
  assign t8c = Q30_ONE - 31'(d7c_q);
  assign c9  = Q30_ONE - 31'(pc8_q >> 1);
  assign sy9 = sgn_q[7] ? -$signed(32'(s8_q)) : $signed(32'(s8_q));
  assign cy9 = $signed(32'(c9));

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      u_q[0]    <= ymag_d[29:0];
      sgn_q[0]  <= y_d[35];
      quad_q[0] <= q_d[1:0];
    end
    for (int k = 1; k < 8; k++) begin
      if (en_i[k]) begin
        sgn_q[k]  <= sgn_q[k-1];
        quad_q[k] <= quad_q[k-1];
      end
    end
    for (int k = 1; k < 7; k++) begin
      if (en_i[k]) u_q[k] <= u_q[k-1];
    end
    if (en_i[1]) u2_q[1] <= sq_d[59:30];
    for (int k = 2; k < 7; k++) begin
      if (en_i[k]) u2_q[k] <= u2_q[k-1];
    end
    if (en_i[2]) begin
      d3s_q <= div_by(u2_q[1], MAG_42, SH_42);
      d3c_q <= div_by(u2_q[1], MAG_56, SH_56);
    end
    if (en_i[3]) begin
      p4s_q <= mul_q30(u2_q[2], t4s);
      p4c_q <= mul_q30(u2_q[2], t4c);
    end
    if (en_i[4]) begin
      d5s_q <= div_by(p4s_q, MAG_20, SH_20);
      d5c_q <= div_by(p4c_q, MAG_30, SH_30);
    end
    if (en_i[5]) begin
      p6s_q <= mul_q30(u2_q[4], t6s);
      p6c_q <= mul_q30(u2_q[4], t6c);
    end
    if (en_i[6]) begin
      d7s_q <= div_by(p6s_q, MAG_6, SH_6);
      d7c_q <= div_by(p6c_q, MAG_12, SH_12);
    end
    if (en_i[7]) begin
      s8_q  <= mul_q30(u_q[6], t8s);
      pc8_q <= mul_q30(u2_q[6], t8c);
    end
    if (en_i[8]) begin
      unique case (quad_q[7])
        2'd0:    begin sin_q <= sy9;  cos_q <= cy9;  end
        2'd1:    begin sin_q <= cy9;  cos_q <= -sy9; end
        2'd2:    begin sin_q <= -sy9; cos_q <= -cy9; end
        default: begin sin_q <= -cy9; cos_q <= sy9;  end
      endcase
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

// File: hw/rtl/dh_link_transform.sv
// Modified DH link transform: 11-stage pipeline, one transfer per cycle in and out unless stalled.
// Throughput: one link per cycle unless stalled; stages: 9 sine/cosine, one product, one rounding.
// Stall: each stage holds only while it is full and the stage after it holds, so bubbles close up.
// Reset (rst_ni low, asynchronous) clears all stage valid bits; payload registers are not reset.
// No configuration; the block has no state between links.
module dh_link_transform import dhlt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic signed [15:0] twist_angle_i,
  input  logic signed [31:0] link_length_i,
  input  logic signed [31:0] link_offset_i,
  input  logic signed [15:0] joint_angle_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic signed [15:0] rot_00_o,
  output logic signed [15:0] rot_01_o,
  output logic signed [15:0] rot_10_o,
  output logic signed [15:0] rot_11_o,
  output logic signed [15:0] rot_12_o,
  output logic signed [15:0] rot_20_o,
  output logic signed [15:0] rot_21_o,
  output logic signed [15:0] rot_22_o,
  output logic signed [31:0] trans_x_o,
  output logic signed [31:0] trans_y_o,
  output logic signed [31:0] trans_z_o
);

  // Round to nearest, ties away from zero, after an arithmetic shift by k.
  function automatic logic signed [63:0] rnd(input logic signed [63:0] v, input int unsigned k);
    logic [63:0] m;
    m = v[63] ? 64'(-v) : 64'(v);
    m = (m + (64'd1 << (k - 1))) >> k;
    return v[63] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Per-stage valid bits; a stage loads when it is empty or its content moves on.
  logic [TOP_STAGES-1:0] valid_q;
  logic [TOP_STAGES-1:0] en;

  always_comb begin
    en[TOP_STAGES-1] = !valid_q[TOP_STAGES-1] || !stall_i;
    for (int k = TOP_STAGES - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  assign stall_o = !en[0];
  assign valid_o = valid_q[TOP_STAGES-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) valid_q[0] <= valid_i;
      for (int k = 1; k < TOP_STAGES; k++) begin
        if (en[k]) valid_q[k] <= valid_q[k-1];
      end
    end
  end

  // Sines and cosines of both angles
  logic signed [31:0] st, ct, sa, ca;

  dhlt_sincos u_sc_theta (
    .clk_i   (clk_i),
    .en_i    (en[SC_STAGES-1:0]),
    .angle_i (joint_angle_i),
    .sin_o   (st),
    .cos_o   (ct)
  );

  dhlt_sincos u_sc_alpha (
    .clk_i   (clk_i),
    .en_i    (en[SC_STAGES-1:0]),
    .angle_i (twist_angle_i),
    .sin_o   (sa),
    .cos_o   (ca)
  );

  // a and d ride alongside the sine/cosine pipeline
  logic signed [31:0] len_q [0:SC_STAGES-1];
  logic signed [31:0] ofs_q [0:SC_STAGES-1];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      len_q[0] <= link_length_i;
      ofs_q[0] <= link_offset_i;
    end
    for (int k = 1; k < SC_STAGES; k++) begin
      if (en[k]) begin
        len_q[k] <= len_q[k-1];
        ofs_q[k] <= ofs_q[k-1];
      end
    end
  end

  // Product stage: full-precision Q60 and Q30 products
  logic signed [31:0] st_q, ct_q, sa_q, ca_q, len_p_q;
  logic signed [63:0] stca_q, ctca_q, stsa_q, ctsa_q, sad_q, cad_q;

  always_ff @(posedge clk_i) begin
    if (en[SC_STAGES]) begin
      st_q    <= st;
      ct_q    <= ct;
      sa_q    <= sa;
      ca_q    <= ca;
      len_p_q <= len_q[SC_STAGES-1];
      stca_q  <= 64'(st) * 64'(ca);
      ctca_q  <= 64'(ct) * 64'(ca);
      stsa_q  <= 64'(st) * 64'(sa);
      ctsa_q  <= 64'(ct) * 64'(sa);
      sad_q   <= 64'(sa) * 64'(ofs_q[SC_STAGES-1]);
      cad_q   <= 64'(ca) * 64'(ofs_q[SC_STAGES-1]);
    end
  end

  // Rounding stage; negated entries negate after rounding (rounding is symmetric).
  logic signed [15:0] r00_q, r01_q, r10_q, r11_q, r12_q, r20_q, r21_q, r22_q;
  logic signed [31:0] tx_q, ty_q, tz_q;

  always_ff @(posedge clk_i) begin
    if (en[TOP_STAGES-1]) begin
      r00_q <= 16'(rnd(64'(ct_q), 16));
      r01_q <= 16'(-rnd(64'(st_q), 16));
      r10_q <= 16'(rnd(stca_q, 46));
      r11_q <= 16'(rnd(ctca_q, 46));
      r12_q <= 16'(-rnd(64'(sa_q), 16));
      r20_q <= 16'(rnd(stsa_q, 46));
      r21_q <= 16'(rnd(ctsa_q, 46));
      r22_q <= 16'(rnd(64'(ca_q), 16));
      tx_q  <= len_p_q;
      ty_q  <= sat32(-rnd(sad_q, 30));
      tz_q  <= sat32(rnd(cad_q, 30));
    end
  end

  assign rot_00_o  = r00_q;
  assign rot_01_o  = r01_q;
  assign rot_10_o  = r10_q;
  assign rot_11_o  = r11_q;
  assign rot_12_o  = r12_q;
  assign rot_20_o  = r20_q;
  assign rot_21_o  = r21_q;
  assign rot_22_o  = r22_q;
  assign trans_x_o = tx_q;
  assign trans_y_o = ty_q;
  assign trans_z_o = tz_q;

endmodule

// File: hw/rtl/dhlt_checker.sv
// Port-level checks for the DH link transform, bound to the top level.
module dhlt_port_checks (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               stall_o,
  input logic               valid_o,
  input logic               stall_i,
  input logic signed [15:0] rot_00_o,
  input logic signed [15:0] rot_22_o,
  input logic signed [31:0] trans_y_o
);

  // output holds while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(trans_y_o) && $stable(rot_00_o))
    else $error("result changed while stalled");

  // input stall only comes from a full pipe backed up by the output
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> valid_o && stall_i)
    else $error("input stalled without output backpressure");

  // rotation entries rot_00 and rot_22 stay within unit magnitude
  a_rot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> rot_00_o <= 16'sd16384 && rot_00_o >= -16'sd16384
             && rot_22_o <= 16'sd16384 && rot_22_o >= -16'sd16384)
    else $error("rotation entry out of range");

  // an empty output stage never stalls input
  a_no_stall_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_o |-> !stall_o)
    else $error("stall with empty output stage");

endmodule

bind dh_link_transform dhlt_port_checks u_dhlt_checker (.*);

// File: verif/dhlt_checker.sv
// Scoreboard for the DH link transform: predicts each link's transform and compares results.
module dhlt_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic               stall_o,
  input  logic signed [15:0] twist_angle_i,
  input  logic signed [31:0] link_length_i,
  input  logic signed [31:0] link_offset_i,
  input  logic signed [15:0] joint_angle_i,
  input  logic               valid_o,
  input  logic               stall_i,
  input  logic signed [15:0] rot_00_o,
  input  logic signed [15:0] rot_01_o,
  input  logic signed [15:0] rot_10_o,
  input  logic signed [15:0] rot_11_o,
  input  logic signed [15:0] rot_12_o,
  input  logic signed [15:0] rot_20_o,
  input  logic signed [15:0] rot_21_o,
  input  logic signed [15:0] rot_22_o,
  input  logic signed [31:0] trans_x_o,
  input  logic signed [31:0] trans_y_o,
  input  logic signed [31:0] trans_z_o,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 checked_o
);

  typedef struct packed {
    logic signed [15:0] r00, r01, r10, r11, r12, r20, r21, r22;
    logic signed [31:0] tx, ty, tz;
  } xform_t;

  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint ONE_Q30     = 64'sd1073741824;

  xform_t expected_xforms[$];

  function automatic longint round_prod(longint a, longint b, int k);
    logic neg;
    logic [63:0] m;
    neg = (a < 0) != (b < 0);
    m = (a < 0 ? -a : a) * (b < 0 ? -b : b);
    m = (m + (64'd1 << (k - 1))) >> k;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Quadrant reduction then Horner series on |y| <= pi/4, all Q30.
  task automatic sincos_q30(input logic signed [15:0] ang, output longint sn,
                            output longint cs);
    longint off, q, y, sy, cy;
    logic [63:0] u, u2, t;
    off = longint'(ang) * 131072 + 4 * HALF_PI_Q30;
    q = (off + HALF_PI_Q30 / 2) / HALF_PI_Q30;
    y = off - q * HALF_PI_Q30;
    u = y < 0 ? -y : y;
    u2 = (u * u) >> 30;
    t = ONE_Q30 - u2 / 42;
    t = ONE_Q30 - ((u2 * t) >> 30) / 20;
    t = ONE_Q30 - ((u2 * t) >> 30) / 6;
    sy = longint'((u * t) >> 30);
    if (y < 0) sy = -sy;
    t = ONE_Q30 - u2 / 56;
    t = ONE_Q30 - ((u2 * t) >> 30) / 30;
    t = ONE_Q30 - ((u2 * t) >> 30) / 12;
    cy = ONE_Q30 - longint'(((u2 * t) >> 30) / 2);
    case (q & 3)
      0: begin sn = sy;  cs = cy;  end
      1: begin sn = cy;  cs = -sy; end
      2: begin sn = -sy; cs = -cy; end
      default: begin sn = -cy; cs = sy; end
    endcase
  endtask

  task automatic predict_xform(input logic signed [15:0] alpha,
                               input logic signed [31:0] a, d,
                               input logic signed [15:0] theta,
                               output xform_t x);
    longint st, ct, sa, ca;
    sincos_q30(theta, st, ct);
    sincos_q30(alpha, sa, ca);
    x.r00 = 16'(round_prod(ct, 1, 16));
    x.r01 = 16'(round_prod(-st, 1, 16));
    x.r10 = 16'(round_prod(st, ca, 46));
    x.r11 = 16'(round_prod(ct, ca, 46));
    x.r12 = 16'(round_prod(-sa, 1, 16));
    x.r20 = 16'(round_prod(st, sa, 46));
    x.r21 = 16'(round_prod(ct, sa, 46));
    x.r22 = 16'(round_prod(ca, 1, 16));
    x.tx  = a;
    x.ty  = 32'(clamp32(round_prod(-sa, longint'(d), 30)));
    x.tz  = 32'(clamp32(round_prod(ca, longint'(d), 30)));
  endtask

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  assign pending_o = expected_xforms.size();

  initial begin
    fail_count_o = 0;
    checked_o = 0;
  end

  always @(posedge clk_i) begin
    xform_t x, e;
    if (rst_ni && valid_i && !stall_o) begin
      predict_xform(twist_angle_i, link_length_i, link_offset_i, joint_angle_i, x);
      expected_xforms.push_back(x);
    end
    if (rst_ni && valid_o && !stall_i) begin
      if (expected_xforms.size() == 0) begin
        $error("result transfer with no link outstanding");
        fail_count_o++;
      end else begin
        e = expected_xforms.pop_front();
        check_field("rot_00", e.r00, rot_00_o);
        check_field("rot_01", e.r01, rot_01_o);
        check_field("rot_10", e.r10, rot_10_o);
        check_field("rot_11", e.r11, rot_11_o);
        check_field("rot_12", e.r12, rot_12_o);
        check_field("rot_20", e.r20, rot_20_o);
        check_field("rot_21", e.r21, rot_21_o);
        check_field("rot_22", e.r22, rot_22_o);
        check_field("trans_x", e.tx, trans_x_o);
        check_field("trans_y", e.ty, trans_y_o);
        check_field("trans_z", e.tz, trans_z_o);
        checked_o++;
      end
    end
  end

endmodule

// File: verif/tb_dh_link_transform.sv
// Testbench top for the DH link transform: stimulus, stall pressure and verdict.
module tb_dh_link_transform;
  import dhlt_pkg::*;

  // 12-unit clock; the cycle counter bounds the run.
  localparam int CYCLE_LIMIT = 200000;
  localparam int N_RANDOM    = 750;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               valid_i = 1'b0;
  logic               stall_o;
  logic signed [15:0] twist_angle_i = '0;
  logic signed [31:0] link_length_i = '0;
  logic signed [31:0] link_offset_i = '0;
  logic signed [15:0] joint_angle_i = '0;
  logic               valid_o;
  logic               stall_i = 1'b0;
  logic signed [15:0] rot_00_o, rot_01_o, rot_10_o, rot_11_o;
  logic signed [15:0] rot_12_o, rot_20_o, rot_21_o, rot_22_o;
  logic signed [31:0] trans_x_o, trans_y_o, trans_z_o;
  int                 fail_count, pending, checked;
  int                 cycle_count = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  dh_link_transform dut (.*);

  dhlt_checker u_checker (
    .*,
    .fail_count_o(fail_count),
    .pending_o(pending),
    .checked_o(checked)
  );

  // Gap length: mostly zero or short, occasionally long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  // Drive one link and hold it until the block takes it. Valid stays high
  // across back-to-back transfers; it only drops for a gap.
  task automatic send_link(logic signed [15:0] alpha, logic signed [31:0] a,
                           logic signed [31:0] d, logic signed [15:0] theta);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    valid_i <= 1'b1;
    twist_angle_i <= alpha;
    link_length_i <= a;
    link_offset_i <= d;
    joint_angle_i <= theta;
    do @(posedge clk_i); while (stall_o);
  endtask

  // Angle picker: in-range values mostly, full 16-bit span sometimes.
  function automatic logic signed [15:0] rand_angle();
    int r;
    r = $urandom_range(9);
    if (r < 6) return 16'($signed($urandom_range(51472)) - 25736);
    if (r < 8) return 16'($urandom);
    // near multiples of pi/4 (6434 in Q3.13) to hit quadrant boundaries
    return 16'($signed($urandom_range(8, 0) - 4) * 6434 + $signed($urandom_range(6)) - 3);
  endfunction

  function automatic logic signed [31:0] rand_len();
    int r;
    r = $urandom_range(9);
    if (r < 6) return 32'($urandom);
    if (r < 8) return 32'($signed($urandom_range(20'hFFFFF)) - 32'sd524288);
    return $urandom_range(1) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
  endfunction

  // Output side: random stall with quiet stretches.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (rst_ni) begin
      if ((cycle_count / 400) % 3 == 2) stall_i <= 1'b0;
      else if ($urandom_range(99) < 6) stall_i <= 1'b1;
      else if ($urandom_range(99) < 30) stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_dh_link_transform failed");
      $finish;
    end
  end

  initial begin
    logic signed [15:0] edge_angles[10];
    edge_angles = '{16'sd0, 16'sd25736, -16'sd25736, 16'sd12868, -16'sd12868,
                    16'sd6434, 16'sh7FFF, 16'sh8000, 16'sd1, -16'sd1};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: angle extremes, quadrant points, saturation of translations.
    foreach (edge_angles[k])
      send_link(edge_angles[k], 32'sh7FFF_FFFF, 32'sh8000_0000, edge_angles[9 - k]);
    send_link(16'sd0, 32'sh8000_0000, 32'sh8000_0000, 16'sd0);       // trans_z = d, the most negative value
    send_link(-16'sd12868, 32'sd0, 32'sh8000_0000, 16'sd0);          // -sin alpha = 1
    send_link(16'sd12868, 32'sd65536, 32'sh7FFF_FFFF, 16'sd12868);
    send_link(16'sd25736, -32'sd1, 32'sh7FFF_FFFF, -16'sd25736);
    send_link(16'sh5555, 32'sh5555_5555, 32'sh5555_5555, 16'shAAAA);
    send_link(16'shAAAA, 32'shAAAA_AAAA, 32'shAAAA_AAAA, 16'sh5555);
    send_link(16'shFFFF, 32'shFFFF_FFFF, 32'shFFFF_FFFF, 16'shFFFF);

    repeat (N_RANDOM) send_link(rand_angle(), rand_len(), rand_len(), rand_angle());
    valid_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (TOP_STAGES + 5) @(posedge clk_i);
    $display("covered %0d link transforms: angle extremes, wrapped angles, quadrant edges,",
             checked);
    $display("saturating translations, with random gaps on input and stalls on output");
    if (fail_count == 0) begin
      $display("tb_dh_link_transform passed");
    end else begin
      $display("tb_dh_link_transform failed");
    end
    $finish;
  end

endmodule
